### hdl/ring_overlay_next_hop_core_macros.svh
// Assertion macros used by the file that checks the next-hop pipeline.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef RING_OVERLAY_NEXT_HOP_CORE_MACROS_SVH
`define RING_OVERLAY_NEXT_HOP_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define RONH_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define RONH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RONH_ASSERT(lbl, ante, cons, msg)
`define RONH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/ronh_pkg.sv
package ronh_pkg;

  // Field widths and ring limits.
  localparam int ID_W        = 6;
  localparam int CNT_W       = 7;
  localparam int MASK_W      = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int MAX_NODES   = 64;
  localparam int NUM_FINGERS = $clog2(MAX_NODES);
  localparam int RED_W       = 2 * CNT_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_ID       = 2'd0,
    REG_NODE_COUNT    = 2'd1,
    REG_NEIGHBOR_MASK = 2'd2
  } cfg_reg_t;

  // Live configuration seen by every stage.
  typedef struct packed {
    logic [ID_W-1:0]   node_id;
    logic [CNT_W-1:0]  ring_n;
    logic [MASK_W-1:0] mask;
  } cfg_t;

  // After stage 1: partly reduced ring positions and the scan candidates.
  typedef struct packed {
    logic [ID_W-1:0]                     target;
    logic [ID_W-1:0]                     dist_t;
    logic                                tgt_linked;
    logic                                is_local;
    logic [MASK_W-1:0]                   cand;
    logic [CNT_W-1:0]                    part_succ;
    logic [NUM_FINGERS-1:0][CNT_W-1:0]   part_fing;
  } s1_t;

  // After stage 2: successor and fingers fully reduced modulo the ring size.
  typedef struct packed {
    logic [ID_W-1:0]                     target;
    logic [ID_W-1:0]                     dist_t;
    logic                                tgt_linked;
    logic                                is_local;
    logic [MASK_W-1:0]                   cand;
    logic [ID_W-1:0]                     succ;
    logic [NUM_FINGERS-1:0][ID_W-1:0]    fing;
  } s2_t;

  // After stage 3: rule decision, with the scan left for the last stage.
  typedef struct packed {
    logic              is_local;
    logic [ID_W-1:0]   hop_pre;
    logic              fail_pre;
    logic              do_scan;
    logic [MASK_W-1:0] cand;
    logic [MASK_W-1:0] lt_rot;
    logic [ID_W-1:0]   dist_succ;
  } s3_t;

  // One result item.
  typedef struct packed {
    logic [ID_W-1:0] next_hop;
    logic            is_local;
    logic            no_route;
  } res_t;

  // Rotate right so that bit sh of v lands at bit 0.
  function automatic logic [MASK_W-1:0] rot_right(input logic [MASK_W-1:0] v,
                                                  input logic [ID_W-1:0] sh);
    logic [2*MASK_W-1:0] w;
    w = {v, v} >> sh;
    return w[MASK_W-1:0];
  endfunction

  // Restoring reduction steps hi down to lo of v modulo n.
  function automatic logic [CNT_W-1:0] ring_reduce(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] n,
                                                   input int hi, input int lo);
    logic [RED_W-1:0] sub;
    logic [CNT_W-1:0] acc;
    acc = v;
    for (int k = hi; k >= lo; k--) begin
      sub = RED_W'(n) << k;
      if (RED_W'(acc) >= sub) begin
        acc = acc - sub[CNT_W-1:0];
      end
    end
    return acc;
  endfunction

  // Position of the highest set bit; zero when none is set.
  function automatic logic [ID_W-1:0] top_bit(input logic [MASK_W-1:0] v);
    logic [ID_W-1:0] p;
    p = '0;
    for (int j = 0; j < MASK_W; j++) begin
      if (v[j]) begin
        p = ID_W'(j);
      end
    end
    return p;
  endfunction

endpackage

### hdl/ronh_in_if.sv
interface ronh_in_if import ronh_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] target_node;

  modport source (output valid, output target_node, input ready);
  modport sink (input valid, input target_node, output ready);
endinterface

### hdl/ronh_out_if.sv
interface ronh_out_if import ronh_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] next_hop;
  logic            is_local;
  logic            no_route;

  modport source (output valid, output next_hop, output is_local, output no_route,
                  input ready);
  modport sink (input valid, input next_hop, input is_local, input no_route,
                output ready);
endinterface

### hdl/ronh_cfg_if.sv
interface ronh_cfg_if import ronh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/ronh_entry.sv
module ronh_entry import ronh_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg,
  input  logic            up_valid,
  input  logic [ID_W-1:0] up_target,
  output logic            up_ready,
  output logic            dn_valid,
  output s1_t             dn_data,
  input  logic            dn_ready
);

  logic              vld_r;
  s1_t               dat_r;
  s1_t               dat_nxt;
  logic [MASK_W-1:0] window;

  // Candidates for the scan lie strictly between self and target on the ring.
  always_comb begin
    dat_nxt.target     = up_target;
    dat_nxt.dist_t     = up_target - cfg.node_id;
    dat_nxt.tgt_linked = cfg.mask[up_target];
    dat_nxt.is_local   = (up_target == cfg.node_id);
    window             = ((MASK_W'(1) << dat_nxt.dist_t) - MASK_W'(1)) & ~MASK_W'(1);
    dat_nxt.cand       = rot_right(cfg.mask, cfg.node_id) & window;
    // Upper three steps of the modulo reduction for successor and fingers.
    dat_nxt.part_succ  = ring_reduce(CNT_W'(cfg.node_id) + CNT_W'(1), cfg.ring_n,
                                     CNT_W - 1, CNT_W - 3);
    for (int i = 0; i < NUM_FINGERS; i++) begin
      dat_nxt.part_fing[i] = ring_reduce(CNT_W'(cfg.node_id) + (CNT_W'(1) << i),
                                         cfg.ring_n, CNT_W - 1, CNT_W - 3);
    end
  end

  // Pipeline register with local stall control.
  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dat_r <= dat_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = dat_r;

endmodule

### hdl/ronh_reduce.sv
module ronh_reduce import ronh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic up_valid,
  input  s1_t  up_data,
  output logic up_ready,
  output logic dn_valid,
  output s2_t  dn_data,
  input  logic dn_ready
);

  logic             vld_r;
  s2_t              dat_r;
  s2_t              dat_nxt;
  logic [CNT_W-1:0] full;

  // Remaining reduction steps; the result is below the ring size.
  always_comb begin
    dat_nxt.target     = up_data.target;
    dat_nxt.dist_t     = up_data.dist_t;
    dat_nxt.tgt_linked = up_data.tgt_linked;
    dat_nxt.is_local   = up_data.is_local;
    dat_nxt.cand       = up_data.cand;
    full               = ring_reduce(up_data.part_succ, cfg.ring_n, CNT_W - 4, 0);
    dat_nxt.succ       = full[ID_W-1:0];
    for (int i = 0; i < NUM_FINGERS; i++) begin
      full            = ring_reduce(up_data.part_fing[i], cfg.ring_n, CNT_W - 4, 0);
      dat_nxt.fing[i] = full[ID_W-1:0];
    end
  end

  // Pipeline register with local stall control.
  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dat_r <= dat_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = dat_r;

endmodule

### hdl/ronh_select.sv
module ronh_select import ronh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic up_valid,
  input  s2_t  up_data,
  output logic up_ready,
  output logic dn_valid,
  output s3_t  dn_data,
  input  logic dn_ready
);

  logic                   vld_r;
  s3_t                    dat_r;
  s3_t                    dat_nxt;
  logic [ID_W-1:0]        dist_succ;
  logic                   succ_hit;
  logic                   succ_linked;
  logic [ID_W-1:0]        dist_f;
  logic                   fing_any;
  logic [ID_W-1:0]        fing_hop;

  // Ring distances are measured clockwise from self on the id space.
  always_comb begin
    dist_succ   = up_data.succ - cfg.node_id;
    succ_hit    = (dist_succ != '0) && (up_data.dist_t <= dist_succ);
    succ_linked = cfg.mask[up_data.succ];

    // Highest finger that exists, is linked and lies short of the target.
    fing_any = 1'b0;
    fing_hop = '0;
    for (int i = 0; i < NUM_FINGERS; i++) begin
      dist_f = up_data.fing[i] - cfg.node_id;
      if (((CNT_W'(1) << i) < cfg.ring_n) && (dist_f != '0) &&
          (dist_f < up_data.dist_t) && cfg.mask[up_data.fing[i]]) begin
        fing_any = 1'b1;
        fing_hop = up_data.fing[i];
      end
    end

    // Rules in priority order; the scan keeps the successor as its default.
    dat_nxt.is_local  = up_data.is_local;
    dat_nxt.do_scan   = 1'b0;
    dat_nxt.hop_pre   = up_data.succ;
    dat_nxt.fail_pre  = !succ_linked;
    if (up_data.is_local) begin
      dat_nxt.hop_pre  = cfg.node_id;
      dat_nxt.fail_pre = 1'b0;
    end else if (up_data.tgt_linked) begin
      dat_nxt.hop_pre  = up_data.target;
      dat_nxt.fail_pre = 1'b0;
    end else if (succ_hit) begin
      dat_nxt.hop_pre  = up_data.succ;
    end else if (fing_any) begin
      dat_nxt.hop_pre  = fing_hop;
      dat_nxt.fail_pre = 1'b0;
    end else begin
      dat_nxt.do_scan  = 1'b1;
    end

    dat_nxt.cand      = up_data.cand;
    dat_nxt.lt_rot    = rot_right((MASK_W'(1) << up_data.succ) - MASK_W'(1),
                                  cfg.node_id);
    dat_nxt.dist_succ = dist_succ;
  end

  // Pipeline register with local stall control.
  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dat_r <= dat_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = dat_r;

endmodule

### hdl/ronh_resolve.sv
module ronh_resolve import ronh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic up_valid,
  input  s3_t  up_data,
  output logic up_ready,
  output logic dn_valid,
  output res_t dn_data,
  input  logic dn_ready
);

  logic              vld_r;
  res_t              dat_r;
  res_t              dat_nxt;
  logic [MASK_W-1:0] cand_a;
  logic [MASK_W-1:0] cand_b;
  logic [MASK_W-1:0] above_succ;
  logic              succ_cand;
  logic              a_exceeds;

  // The scan ends on the candidate nearest the target, except that once the
  // successor itself is taken, only ids above it can replace it.
  always_comb begin
    cand_a     = up_data.cand & up_data.lt_rot;
    cand_b     = up_data.cand & ~up_data.lt_rot & ~(MASK_W'(1) << up_data.dist_succ);
    above_succ = ~((MASK_W'(2) << up_data.dist_succ) - MASK_W'(1));
    succ_cand  = up_data.cand[up_data.dist_succ];
    a_exceeds  = |(cand_a & above_succ);

    dat_nxt.is_local = up_data.is_local;
    dat_nxt.next_hop = up_data.hop_pre;
    dat_nxt.no_route = up_data.fail_pre;
    if (up_data.do_scan && (|up_data.cand)) begin
      if (succ_cand && !a_exceeds) begin
        if (|cand_b) begin
          dat_nxt.next_hop = cfg.node_id + top_bit(cand_b);
          dat_nxt.no_route = 1'b0;
        end
      end else begin
        dat_nxt.next_hop = cfg.node_id + top_bit(up_data.cand);
        dat_nxt.no_route = 1'b0;
      end
    end
  end

  // Output register; it holds the result until the receiver takes it.
  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dat_r <= dat_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = dat_r;

endmodule

### hdl/ring_overlay_next_hop_core.sv
// Next-hop lookup for a node on a ring overlay.
// in_chan carries one destination id per transfer; out_chan returns one
// result per destination: the node to forward to, a local flag and a
// no-route flag for a hop that has no direct link. cfg_chan writes the
// node id (index 0), the ring size (index 1) and the neighbor mask
// (index 2); other indexes are accepted and ignored. Writes are always
// accepted and belong to quiet periods with no lookup in flight.
// The pipeline takes one destination every cycle while the receiver is
// ready; it has four register stages, with the modulo reduction of
// successor and fingers split over the first two and the scan's
// leading-one search in the last.
// When the receiver stalls, the result holds in the output register and
// each stage keeps accepting until it is full, so ready falls back to the
// input only once the whole pipeline is occupied; nothing is dropped.
// A synchronous reset empties the pipeline and sets node id 0, ring size 1
// and an empty neighbor mask.
`include "ring_overlay_next_hop_core_macros.svh"
module ring_overlay_next_hop_core import ronh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ronh_in_if.sink    in_chan,
  ronh_out_if.source out_chan,
  ronh_cfg_if.sink   cfg_chan
);

  logic [ID_W-1:0]   node_id_r;
  logic [CNT_W-1:0]  node_count_r;
  logic [MASK_W-1:0] neighbor_mask_r;
  cfg_t              cfg;

  logic s1_vld, s1_rdy;
  s1_t  s1_dat;
  logic s2_vld, s2_rdy;
  s2_t  s2_dat;
  logic s3_vld, s3_rdy;
  s3_t  s3_dat;
  res_t res;

  // Configuration registers.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r       <= '0;
      node_count_r    <= CNT_W'(1);
      neighbor_mask_r <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_NODE_ID:       node_id_r       <= cfg_chan.data[ID_W-1:0];
        REG_NODE_COUNT:    node_count_r    <= cfg_chan.data[CNT_W-1:0];
        REG_NEIGHBOR_MASK: neighbor_mask_r <= cfg_chan.data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring size clamped to one through the largest supported ring.
  always_comb begin
    cfg.node_id = node_id_r;
    cfg.mask    = neighbor_mask_r;
    if (node_count_r == '0) begin
      cfg.ring_n = CNT_W'(1);
    end else if (node_count_r > CNT_W'(MAX_NODES)) begin
      cfg.ring_n = CNT_W'(MAX_NODES);
    end else begin
      cfg.ring_n = node_count_r;
    end
  end

  // Four-stage lookup pipeline.
  ronh_entry u_entry (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .up_valid  (in_chan.valid),
    .up_target (in_chan.target_node),
    .up_ready  (in_chan.ready),
    .dn_valid  (s1_vld),
    .dn_data   (s1_dat),
    .dn_ready  (s1_rdy)
  );

  ronh_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (s1_vld),
    .up_data  (s1_dat),
    .up_ready (s1_rdy),
    .dn_valid (s2_vld),
    .dn_data  (s2_dat),
    .dn_ready (s2_rdy)
  );

  ronh_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (s2_vld),
    .up_data  (s2_dat),
    .up_ready (s2_rdy),
    .dn_valid (s3_vld),
    .dn_data  (s3_dat),
    .dn_ready (s3_rdy)
  );

  ronh_resolve u_resolve (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (s3_vld),
    .up_data  (s3_dat),
    .up_ready (s3_rdy),
    .dn_valid (out_chan.valid),
    .dn_data  (res),
    .dn_ready (out_chan.ready)
  );

  assign out_chan.next_hop = res.next_hop;
  assign out_chan.is_local = res.is_local;
  assign out_chan.no_route = res.no_route;

  // A local result names this node and never reports a missing route.
  `RONH_ASSERT(a_local_hop, out_chan.valid && out_chan.is_local,
               out_chan.next_hop == node_id_r && !out_chan.no_route,
               "local result does not name this node")
  // For a forwarded result the no-route flag mirrors the link of the hop.
  `RONH_ASSERT(a_route_flag, out_chan.valid && !out_chan.is_local,
               out_chan.no_route == !neighbor_mask_r[out_chan.next_hop],
               "no_route disagrees with neighbor mask")
  // An accepted destination always occupies the first stage next cycle.
  `RONH_ASSERT_NEXT(a_entry_load, in_chan.valid && in_chan.ready, s1_vld,
                    "input transfer lost at first stage")

endmodule
